/* rtl/iis_pkg.sv */
package iis_pkg;

    // Configuration register layout.
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH  = 1'b0,
        CFG_FRAME_HEIGHT = 1'b1
    } t_cfg_idx;

    localparam logic [CFG_W-1:0] CFG_SIZE_RESET = 11'd1024;

    // Data path widths.
    localparam int PIX_W = 8;
    localparam int ROW_W = 18;
    localparam int SUM_W = 28;

    typedef logic [SUM_W-1:0] t_sum;
    typedef logic [ROW_W-1:0] t_row_sum;

endpackage

/* rtl/iis_ram.sv */
module iis_ram #(
    parameter int WIDTH = 28,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port and one registered read port; read data holds between reads.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/integral_image_stream.sv */
// Channel   Direction  Handshake                    Word
// pixel     in         i_pix_valid / o_pix_ready    i_pixel_value
// result    out        o_sum_valid / i_sum_ready    o_integral_sum, o_frame_end
// config    in         i_cfg_we (no wait)           i_cfg_addr, i_cfg_wdata
//
// One pixel per clock is accepted unless results stall; results are registered.
// The rate is set by the single line store port pair: one read and one write per cycle.
// Reset is synchronous and active low; the line store is not cleared, since the
// top row of a frame never uses what it reads.
// A stall on the result side holds the item in the middle stage and the output
// register, and the pixel side is held off only when both are full.
module integral_image_stream
    import iis_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_addr,
    input  logic [CFG_W-1:0]     i_cfg_wdata,
    input  logic                 i_pix_valid,
    output logic                 o_pix_ready,
    input  logic [PIX_W-1:0]     i_pixel_value,
    output logic                 o_sum_valid,
    input  logic                 i_sum_ready,
    output logic [SUM_W-1:0]     o_integral_sum,
    output logic                 o_frame_end
);

    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int RW   = $clog2(MAX_HEIGHT);
    localparam int WW   = $clog2(MAX_WIDTH + 1);
    localparam int HW   = $clog2(MAX_HEIGHT + 1);
    localparam int SZA  = (WW > HW) ? WW : HW;
    localparam int SZW  = (SZA > CFG_W) ? SZA : CFG_W;

    // Configuration registers.
    logic [CFG_W-1:0] r_frame_width;
    logic [CFG_W-1:0] r_frame_height;

    // Position and row sum state.
    logic [CW-1:0] r_col, n_col;
    logic [RW-1:0] r_row, n_row;
    t_row_sum      r_rowsum, n_rowsum;

    // Middle stage, waiting for line store data.
    logic          r_s1_valid;
    logic [CW-1:0] r_s1_col;
    t_row_sum      r_s1_rowsum;
    logic          r_s1_top;
    logic          r_s1_last;
    logic          r_s1_fwd;
    t_sum          r_s1_fwd_data;

    // Output register.
    logic          r_out_valid;
    t_sum          r_out_sum;
    logic          r_out_end;

    logic          pix_acc;
    logic          s1_adv;
    logic [SZW-1:0] eff_w;
    logic [SZW-1:0] eff_h;
    logic [SZW-1:0] col_inc;
    logic [SZW-1:0] row_inc;
    logic          row_last;
    logic          frame_last;
    t_row_sum      rowsum_new;
    t_sum          ram_rdata;
    t_sum          above;
    t_sum          s1_sum;
    logic          fwd_now;

    // Handshakes: the middle stage moves when the output register is free or drains.
    assign s1_adv      = r_s1_valid && (!r_out_valid || i_sum_ready);
    assign o_pix_ready = !r_s1_valid || s1_adv;
    assign pix_acc     = i_pix_valid && o_pix_ready;

    // Effective frame size: zero acts as one, oversize is clamped.
    always_comb begin
        eff_w = SZW'(r_frame_width);
        if (r_frame_width == '0) begin
            eff_w = SZW'(1);
        end else if (eff_w > SZW'(MAX_WIDTH)) begin
            eff_w = SZW'(MAX_WIDTH);
        end
        eff_h = SZW'(r_frame_height);
        if (r_frame_height == '0) begin
            eff_h = SZW'(1);
        end else if (eff_h > SZW'(MAX_HEIGHT)) begin
            eff_h = SZW'(MAX_HEIGHT);
        end
    end

    // Position decode and the next counter values for an accepted pixel.
    assign col_inc    = SZW'(r_col) + SZW'(1);
    assign row_inc    = SZW'(r_row) + SZW'(1);
    assign row_last   = (col_inc >= eff_w);
    assign frame_last = row_last && (row_inc >= eff_h);
    assign rowsum_new = r_rowsum + ROW_W'(i_pixel_value);

    always_comb begin
        n_col    = r_col;
        n_row    = r_row;
        n_rowsum = r_rowsum;
        if (pix_acc) begin
            if (row_last) begin
                n_col    = '0;
                n_rowsum = '0;
                n_row    = frame_last ? '0 : RW'(r_row + RW'(1));
            end else begin
                n_col    = CW'(r_col + CW'(1));
                n_rowsum = rowsum_new;
            end
        end
    end

    // Line store: read on accept, written back when the middle stage moves on.
    iis_ram #(
        .WIDTH (SUM_W),
        .DEPTH (MAX_WIDTH)
    ) u_line (
        .i_clk   (i_clk),
        .i_we    (s1_adv),
        .i_waddr (r_s1_col),
        .i_wdata (s1_sum),
        .i_re    (pix_acc),
        .i_raddr (r_col),
        .o_rdata (ram_rdata)
    );

    // A read of the column being written in the same cycle takes the new value.
    assign fwd_now = s1_adv && (r_s1_col == r_col);

    // Sum of the value above and the running row sum; the top row has nothing above.
    always_comb begin
        if (r_s1_top) begin
            above = '0;
        end else if (r_s1_fwd) begin
            above = r_s1_fwd_data;
        end else begin
            above = ram_rdata;
        end
    end

    assign s1_sum = above + SUM_W'(r_s1_rowsum);

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= CFG_SIZE_RESET;
            r_frame_height <= CFG_SIZE_RESET;
            r_col          <= '0;
            r_row          <= '0;
            r_rowsum       <= '0;
            r_s1_valid     <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_addr))
                    CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg_wdata;
                    CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_wdata;
                    default: ;
                endcase
            end
            r_col    <= n_col;
            r_row    <= n_row;
            r_rowsum <= n_rowsum;
            if (pix_acc) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_sum_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (pix_acc) begin
            r_s1_col      <= r_col;
            r_s1_rowsum   <= rowsum_new;
            r_s1_top      <= (r_row == '0);
            r_s1_last     <= frame_last;
            r_s1_fwd      <= fwd_now;
            r_s1_fwd_data <= s1_sum;
        end
        if (s1_adv) begin
            r_out_sum <= s1_sum;
            r_out_end <= r_s1_last;
        end
    end

    assign o_sum_valid    = r_out_valid;
    assign o_integral_sum = r_out_sum;
    assign o_frame_end    = r_out_end;

`ifndef SYNTH
    // The end of a row always sends the column counter back to zero.
    a_row_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pix_acc && row_last) |=> (r_col == '0))
        else $error("column counter did not restart at the end of a row");

    // With both stages full and the output stalled, no pixel may enter.
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_out_valid && !i_sum_ready) |-> !o_pix_ready)
        else $error("pixel accepted while the pipeline is full");

    // Whatever leaves the middle stage shows up as a result in the next cycle.
    a_adv_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_adv |=> o_sum_valid)
        else $error("middle stage advanced without producing a result");
`endif

endmodule
